// ===== design/interval_reservation_table_defines.svh =====
// Assertion macros for the interval reservation table.
`ifndef INTERVAL_RESERVATION_TABLE_DEFINES_SVH
`define INTERVAL_RESERVATION_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IRT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IRT_ASSERT(label, clk, rst_n, prop, msg)
`define IRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/irt_pkg.sv =====
// ----------------------------------------------------------------------------
// irt_pkg
// Shared constants and types of the interval reservation table.
// ----------------------------------------------------------------------------
package irt_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int TIME_BITS   = 32;
    localparam int ID_BITS     = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CHECK  = 2'd2;
    localparam logic [1:0] REQ_SLOT   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVERLAP = 3'd1;
    localparam logic [2:0] ST_NO_ID   = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ID_BITS-1:0]   id_t;

    // one table entry as read by the scanner
    typedef struct packed {
        logic  valid;
        id_t   tag;
        time_t begin_t;
        time_t finish_t;
    } entry_t;

    // table write command from the scanner
    typedef struct packed {
        logic                en;
        logic                set;
        logic [IDX_BITS-1:0] idx;
        id_t                 tag;
        time_t               begin_t;
        time_t               finish_t;
    } wr_t;
endpackage

// ===== design/interval_reservation_table.sv =====
// ----------------------------------------------------------------------------
// interval_reservation_table
// Table of disjoint half-open intervals with add, remove, check and find-slot.
// ----------------------------------------------------------------------------
// Each request word takes the bus, then one sequencer walks the 32 table
// entries through a single registered memory read port and one comparator
// datapath. Add, remove and check take one scan pass, then the commit state
// and the output state, before the result word is valid. An empty request,
// or a find-slot on an empty table, answers in the cycle after acceptance.
// Find-slot needs the stored entries in start order, so it repeats a scan
// pass plus commit per stored entry, each pass picking the next entry by
// start time, and ends with one more pass that finds no further entry. The
// result word sits in an output register; the next request is taken from
// the cycle after it has been handed off.
module interval_reservation_table
    import irt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: req_type[1:0] event_id[17:2] start_time[49:18] end_time[81:50]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0] hit[3] hit_id[19:4] hit_start[51:20] hit_end[83:52]
    //        slot_start[115:84] stored_count[121:116]
    output logic [127:0] m_tdata
);
`include "interval_reservation_table_defines.svh"

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_t;

    localparam logic [TIME_BITS:0] TMAX = {1'b0, {TIME_BITS{1'b1}}};

    state_t state_reg;
    logic [1:0]          op_reg;
    id_t                 id_reg;
    time_t               s_reg, e_reg;
    logic [IDX_BITS:0]   cnt_reg;     // scan address counter, one past depth
    logic                rvld_reg;    // read data valid this cycle
    logic [IDX_BITS-1:0] ridx_reg;    // index of data now on read port
    logic [CNT_BITS-1:0] total_reg;
    // best entry of a scan
    logic                bf_reg;
    logic [IDX_BITS-1:0] bi_reg;
    id_t                 bt_reg;
    time_t               bb_reg, bfin_reg;
    logic                ff_reg;      // first free slot seen
    logic [IDX_BITS-1:0] fi_reg;
    // find-slot: previous gap start, previous begin, gap pass state
    time_t               gs_reg, pb_reg;
    logic                pf_reg;      // a previous entry exists
    logic                sf_reg;      // best slot found
    logic [TIME_BITS:0]  sd_reg;
    time_t               sv_reg;
    logic [127:0]        out_reg;
    logic                ovld_reg;

    entry_t rd;
    wr_t    wr;

    irt_store u_store (.clk(clk), .rst_n(rst_n), .rd_idx(cnt_reg[IDX_BITS-1:0]),
                       .rd_data(rd), .wr(wr));

    assign s_tready = (state_reg == S_IDLE) && !ovld_reg;
    assign m_tvalid = ovld_reg;
    assign m_tdata  = out_reg;

    // per-entry tests on the read port
    logic ov, better, eligible, cand;
    always_comb
    begin
        ov       = rd.valid && (rd.begin_t < e_reg) && (s_reg < rd.finish_t);
        better   = !bf_reg || (rd.begin_t < bb_reg);
        // next entry in start order: begins after the previous one taken
        // (begins are distinct since entries are disjoint and nonempty)
        eligible = rd.valid && (!pf_reg || rd.begin_t > pb_reg);
        case (op_reg)
            REQ_ADD, REQ_CHECK: cand = ov && better;
            REQ_REMOVE:         cand = rd.valid && rd.tag == id_reg && better;
            default:            cand = eligible && better;
        endcase
    end

    // gap evaluation: gap [gs, ge) with candidate clamp
    logic [TIME_BITS:0] dur, ge, c, d;
    logic gfit;
    always_comb
    begin
        dur  = {1'b0, e_reg} - {1'b0, s_reg};
        ge   = bf_reg ? {1'b0, bb_reg} : TMAX;
        gfit = (ge >= {1'b0, gs_reg}) && (ge - {1'b0, gs_reg} >= dur);
        c    = ({1'b0, s_reg} < ge - dur) ? {1'b0, s_reg} : ge - dur;
        if (c < {1'b0, gs_reg})
        begin
            c = {1'b0, gs_reg};
        end
        d    = (c > {1'b0, s_reg}) ? c - {1'b0, s_reg} : {1'b0, s_reg} - c;
    end

    function automatic logic [127:0] pack(logic [2:0] st, logic h, id_t hid,
                                          time_t hs, time_t he, time_t sl,
                                          logic [CNT_BITS-1:0] n);
        logic [127:0] w;
        w = '0;
        w[2:0] = st;   w[3] = h;       w[19:4] = hid;
        w[51:20] = hs; w[83:52] = he;  w[115:84] = sl;
        w[121:116] = n;
        return w;
    endfunction

    always_comb
    begin
        wr = '0;
        wr.tag = id_reg; wr.begin_t = s_reg; wr.finish_t = e_reg;
        if (state_reg == S_COMMIT)
        begin
            if (op_reg == REQ_ADD && !bf_reg && ff_reg)
            begin
                wr.en = 1'b1; wr.set = 1'b1; wr.idx = fi_reg;
            end
            else if (op_reg == REQ_REMOVE && bf_reg)
            begin
                wr.en = 1'b1; wr.set = 1'b0; wr.idx = bi_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
            total_reg <= '0;
            cnt_reg   <= '0;
            rvld_reg  <= 1'b0;
            out_reg   <= '0;
            op_reg    <= REQ_ADD;
            id_reg    <= '0;
            s_reg     <= '0;
            e_reg     <= '0;
            ridx_reg  <= '0;
            bf_reg    <= 1'b0;
            bi_reg    <= '0;
            bt_reg    <= '0;
            bb_reg    <= '0;
            bfin_reg  <= '0;
            ff_reg    <= 1'b0;
            fi_reg    <= '0;
            gs_reg    <= '0;
            pb_reg    <= '0;
            pf_reg    <= 1'b0;
            sf_reg    <= 1'b0;
            sd_reg    <= '0;
            sv_reg    <= '0;
        end
        else
        begin
            if (ovld_reg && m_tready)
            begin
                ovld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg <= s_tdata[1:0];
                        id_reg <= s_tdata[17:2];
                        s_reg  <= s_tdata[49:18];
                        e_reg  <= s_tdata[81:50];
                        cnt_reg <= '0; rvld_reg <= 1'b0;
                        bf_reg <= 1'b0; ff_reg <= 1'b0;
                        pf_reg <= 1'b0; sf_reg <= 1'b0;
                        gs_reg <= '0;
                        if (s_tdata[49:18] >= s_tdata[81:50])
                        begin
                            out_reg  <= pack(ST_EMPTY, 1'b0, '0, '0, '0, '0, total_reg);
                            ovld_reg <= 1'b1;
                        end
                        else if (s_tdata[1:0] == REQ_SLOT && total_reg == '0)
                        begin
                            out_reg  <= pack(ST_OK, 1'b0, '0, '0, '0,
                                             s_tdata[49:18], total_reg);
                            ovld_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    rvld_reg <= (cnt_reg < (IDX_BITS+1)'(TABLE_DEPTH));
                    ridx_reg <= cnt_reg[IDX_BITS-1:0];
                    if (cnt_reg < (IDX_BITS+1)'(TABLE_DEPTH))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rvld_reg)
                    begin
                        if (cand)
                        begin
                            bf_reg <= 1'b1; bi_reg <= ridx_reg; bt_reg <= rd.tag;
                            bb_reg <= rd.begin_t; bfin_reg <= rd.finish_t;
                        end
                        if (!rd.valid && !ff_reg)
                        begin
                            ff_reg <= 1'b1; fi_reg <= ridx_reg;
                        end
                    end
                    else if (cnt_reg == (IDX_BITS+1)'(TABLE_DEPTH))
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    // find-slot rescans while another entry remains
                    state_reg <= (op_reg == REQ_SLOT && bf_reg) ? S_SCAN : S_OUT;
                    case (op_reg)
                        REQ_ADD:
                        begin
                            if (bf_reg)
                                out_reg <= pack(ST_OVERLAP, 1'b0, '0, '0, '0, '0, total_reg);
                            else if (!ff_reg)
                                out_reg <= pack(ST_FULL, 1'b0, '0, '0, '0, '0, total_reg);
                            else
                            begin
                                out_reg <= pack(ST_OK, 1'b0, '0, '0, '0, '0,
                                                total_reg + 1'b1);
                                total_reg <= total_reg + 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!bf_reg)
                                out_reg <= pack(ST_NO_ID, 1'b0, '0, '0, '0, '0, total_reg);
                            else
                            begin
                                out_reg <= pack(ST_OK, 1'b0, '0, '0, '0, '0,
                                                total_reg - 1'b1);
                                total_reg <= total_reg - 1'b1;
                            end
                        end
                        REQ_CHECK:
                        begin
                            if (bf_reg)
                                out_reg <= pack(ST_OK, 1'b1, bt_reg, bb_reg, bfin_reg,
                                                '0, total_reg);
                            else
                                out_reg <= pack(ST_OK, 1'b0, '0, '0, '0, '0, total_reg);
                        end
                        default:
                        begin
                            // one gap per pass; gap after last ends at max
                            if (gfit && (!sf_reg || d < sd_reg))
                            begin
                                sf_reg <= 1'b1; sd_reg <= d; sv_reg <= c[TIME_BITS-1:0];
                            end
                            if (bf_reg)
                            begin
                                gs_reg <= bfin_reg; pb_reg <= bb_reg; pf_reg <= 1'b1;
                                bf_reg <= 1'b0; cnt_reg <= '0; rvld_reg <= 1'b0;
                            end
                            else if (gfit && (!sf_reg || d < sd_reg))
                                out_reg <= pack(ST_OK, 1'b0, '0, '0, '0,
                                                c[TIME_BITS-1:0], total_reg);
                            else if (sf_reg)
                                out_reg <= pack(ST_OK, 1'b0, '0, '0, '0, sv_reg, total_reg);
                            else
                                out_reg <= pack(ST_OVERLAP, 1'b0, '0, '0, '0, '0, total_reg);
                        end
                    endcase
                end
                S_OUT:
                begin
                    ovld_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `IRT_ASSERT(a_ready_idle, clk, rst_n, s_tready |-> state_reg == S_IDLE, "ready outside idle")
    `IRT_ASSERT(a_count_max, clk, rst_n, total_reg <= CNT_BITS'(TABLE_DEPTH), "count overflow")
    `IRT_ASSERT(a_no_accept_busy, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "accept while busy")
    `IRT_ASSERT(a_wr_commit, clk, rst_n, wr.en |-> state_reg == S_COMMIT, "write outside commit")
endmodule

// ===== design/irt_store.sv =====
// ----------------------------------------------------------------------------
// irt_store
// Entry storage: valid bits in flip-flops, payload in a memory with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module irt_store
    import irt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_BITS-1:0] rd_idx,
    output entry_t              rd_data,
    input  wr_t                 wr
);
    logic [TABLE_DEPTH-1:0] valid_reg;
    id_t   tag_mem    [TABLE_DEPTH];
    time_t begin_mem  [TABLE_DEPTH];
    time_t finish_mem [TABLE_DEPTH];
    logic  rd_valid_reg;
    id_t   rd_tag_reg;
    time_t rd_begin_reg;
    time_t rd_finish_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= wr.set;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.set)
        begin
            tag_mem[wr.idx]    <= wr.tag;
            begin_mem[wr.idx]  <= wr.begin_t;
            finish_mem[wr.idx] <= wr.finish_t;
        end
        rd_tag_reg    <= tag_mem[rd_idx];
        rd_begin_reg  <= begin_mem[rd_idx];
        rd_finish_reg <= finish_mem[rd_idx];
    end

    assign rd_data = '{valid: rd_valid_reg, tag: rd_tag_reg,
                       begin_t: rd_begin_reg, finish_t: rd_finish_reg};
endmodule
